// File: rtl/core/srsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window unit.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int SEQ_SPACE_DEF = 16;

  localparam int FUNC_W     = 2;
  localparam int SEQ_FW     = 4;
  localparam int ACTION_W   = 3;
  localparam int WIN_W      = 4;
  localparam int RF_W       = 6;
  localparam int RETRY_W    = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [WIN_W-1:0]   WIN_RST   = 4'd1;
  localparam logic [RF_W-1:0]    RF_RST    = 6'd20;
  localparam logic [RETRY_W-1:0] RETRY_MAX = 10'd1023;
  localparam logic [RETRY_W-1:0] RETRY_ONE = 10'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_RETRY  = 1'b1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEND    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SENT    = 3'd0,
    ACT_REFUSED = 3'd1,
    ACT_ACK_OK  = 3'd2,
    ACT_IGNORED = 3'd3,
    ACT_RETX    = 3'd4,
    ACT_ABORT   = 3'd5
  } action_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DNEXT  = 6'b000010,
    ST_DSN    = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_SLIDE  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  typedef enum logic {
    OP_SUB = 1'b0,
    OP_INC = 1'b1
  } op_t;

  typedef struct packed {
    action_t            action;
    logic [SEQ_FW-1:0]  seq_out;
    logic               timer_start;
    logic               timer_stop;
    logic [SEQ_FW-1:0]  window_base;
    logic               all_acked;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/selective_repeat_sender_window_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sequence-number bookkeeping of a selective-repeat ARQ sender.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction steps through DNEXT, DSN and DECIDE to DONE;
//   an accepted acknowledgement passes through SLIDE, one base step per slide.
// Issue: no new transaction is taken until the result leaves DONE, as the
//   sequencer steps the shared modulo unit through one transaction at a time.
// Reset: synchronous rst_n clears the window, marks, retry count and abort;
//   window_size returns to 1 and retry_factor to 20.
module selective_repeat_sender_window_unit
  import srsw_pkg::*;
#(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [SEQ_FW-1:0]     in_seq_num,
  input  logic                  in_check_ok,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ACTION_W-1:0]   out_action,
  output logic [SEQ_FW-1:0]     out_seq_out,
  output logic                  out_timer_start,
  output logic                  out_timer_stop,
  output logic [SEQ_FW-1:0]     out_window_base,
  output logic                  out_all_acked,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [WIN_W-1:0] window_r;
  logic [RF_W-1:0]  factor_r;
  logic             item_ready;
  logic             res_valid;
  logic             res_take;
  result_t          res;
  result_t          out_r;
  logic             out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RST;
      factor_r <= RF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
        REG_RETRY:  factor_r <= cfg_wdata[RF_W-1:0];
        default:    window_r <= window_r;
      endcase
    end
  end

  srsw_ctrl #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (in_valid),
    .item_ready    (item_ready),
    .item_func     (in_func),
    .item_seq_num  (in_seq_num),
    .item_check_ok (in_check_ok),
    .window_size   (window_r),
    .retry_factor  (factor_r),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  assign in_stall = !item_ready;
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.action;
  assign out_seq_out     = out_r.seq_out;
  assign out_timer_start = out_r.timer_start;
  assign out_timer_stop  = out_r.timer_stop;
  assign out_window_base = out_r.window_base;
  assign out_all_acked   = out_r.all_acked;

endmodule
`default_nettype wire

// File: rtl/core/srsw_modu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_modu
// Shared modulo-sequence-space unit: distance (a - b) mod space, or (a + 1) mod space.
// ----------------------------------------------------------------------------
module srsw_modu
  import srsw_pkg::*;
#(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF,
  parameter int SEQ_W     = $clog2(SEQ_SPACE)
) (
  input  op_t              op,
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W-1:0] b,
  output logic [SEQ_W-1:0] y
);

  logic [SEQ_W:0] diff;

  always_comb begin
    diff = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      diff = diff + (SEQ_W + 1)'(SEQ_SPACE);
    end
    case (op)
      OP_SUB: y = diff[SEQ_W-1:0];
      OP_INC: y = (a == SEQ_W'(SEQ_SPACE - 1)) ? '0 : a + 1'b1;
      default: y = diff[SEQ_W-1:0];
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/srsw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_ctrl
// Event sequencer: window state, acknowledgement marks, retry count and the
// base slide; its distances and sequence increments share one modulo unit.
// ----------------------------------------------------------------------------
module srsw_ctrl
  import srsw_pkg::*;
#(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [FUNC_W-1:0] item_func,
  input  logic [SEQ_FW-1:0] item_seq_num,
  input  logic              item_check_ok,
  input  logic [WIN_W-1:0]  window_size,
  input  logic [RF_W-1:0]   retry_factor,
  output logic              res_valid,
  input  logic              res_take,
  output result_t           res
);

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int CW    = (SEQ_W > WIN_W) ? SEQ_W : WIN_W;
  localparam int SNW   = (SEQ_W + 1 > SEQ_FW + 1) ? SEQ_W + 1 : SEQ_FW + 1;

  state_t               state_r, state_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [SEQ_W-1:0]     next_r, next_nxt;
  logic [SEQ_SPACE-1:0] marks_r, marks_nxt;
  logic [RETRY_W-1:0]   retry_r, retry_nxt;
  logic                 aborted_r, aborted_nxt;

  func_t                func_r;
  logic [SEQ_FW-1:0]    sn_r;
  logic [SEQ_W-1:0]     sn_idx_r;
  logic                 sn_in_r;
  logic                 chk_r;
  logic [SEQ_W-1:0]     dnext_r;
  logic [SEQ_W-1:0]     dsn_r;
  logic [RETRY_W-1:0]   thr_r;
  action_t              action_r, action_nxt;
  logic [SEQ_FW-1:0]    seqo_r, seqo_nxt;
  logic                 tstart_r, tstart_nxt;
  logic                 tstop_r, tstop_nxt;

  op_t                  alu_op;
  logic [SEQ_W-1:0]     alu_a;
  logic [SEQ_W-1:0]     alu_b;
  logic [SEQ_W-1:0]     alu_y;

  logic [CW-1:0]        eff_win;
  logic [RETRY_W-1:0]   retry_inc;
  logic                 accept;

  srsw_modu #(
    .SEQ_SPACE (SEQ_SPACE),
    .SEQ_W     (SEQ_W)
  ) u_modu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign item_ready = (state_r == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign res_valid  = (state_r == ST_DONE);

  assign res.action      = action_r;
  assign res.seq_out     = seqo_r;
  assign res.timer_start = tstart_r;
  assign res.timer_stop  = tstop_r;
  assign res.window_base = SEQ_FW'(base_r);
  assign res.all_acked   = (base_r == next_r);

  always_comb begin
    case (state_r)
      ST_DNEXT: begin
        alu_op = OP_SUB;
        alu_a  = next_r;
        alu_b  = base_r;
      end
      ST_DSN: begin
        alu_op = OP_SUB;
        alu_a  = sn_idx_r;
        alu_b  = base_r;
      end
      ST_DECIDE: begin
        alu_op = OP_INC;
        alu_a  = next_r;
        alu_b  = base_r;
      end
      ST_SLIDE: begin
        alu_op = OP_INC;
        alu_a  = base_r;
        alu_b  = next_r;
      end
      default: begin
        alu_op = OP_SUB;
        alu_a  = next_r;
        alu_b  = base_r;
      end
    endcase
  end

  always_comb begin
    eff_win = CW'(window_size);
    if (CW'(window_size) > CW'(SEQ_SPACE - 1)) begin
      eff_win = CW'(SEQ_SPACE - 1);
    end
    retry_inc = (retry_r < RETRY_MAX) ? retry_r + 1'b1 : retry_r;
  end

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    next_nxt    = next_r;
    marks_nxt   = marks_r;
    retry_nxt   = retry_r;
    aborted_nxt = aborted_r;
    action_nxt  = action_r;
    seqo_nxt    = seqo_r;
    tstart_nxt  = tstart_r;
    tstop_nxt   = tstop_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = ST_DNEXT;
        end
      end
      ST_DNEXT: state_nxt = ST_DSN;
      ST_DSN:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        action_nxt = ACT_IGNORED;
        seqo_nxt   = sn_r;
        tstart_nxt = 1'b0;
        tstop_nxt  = 1'b0;
        state_nxt  = ST_DONE;
        if (aborted_r) begin
          action_nxt = ACT_ABORT;
          seqo_nxt   = '0;
        end else begin
          case (func_r)
            FUNC_SEND: begin
              seqo_nxt = SEQ_FW'(next_r);
              if (CW'(dnext_r) < eff_win) begin
                action_nxt = ACT_SENT;
                tstart_nxt = 1'b1;
                retry_nxt  = RETRY_ONE;
                next_nxt   = alu_y;
              end else begin
                action_nxt = ACT_REFUSED;
              end
            end
            FUNC_ACK: begin
              if (chk_r && sn_in_r && (dsn_r < dnext_r)) begin
                action_nxt          = ACT_ACK_OK;
                tstop_nxt           = 1'b1;
                marks_nxt[sn_idx_r] = 1'b1;
                state_nxt           = ST_SLIDE;
              end
            end
            FUNC_TIMEOUT: begin
              retry_nxt = retry_inc;
              if (retry_inc > thr_r) begin
                aborted_nxt = 1'b1;
                action_nxt  = ACT_ABORT;
              end else begin
                action_nxt = ACT_RETX;
                tstart_nxt = 1'b1;
              end
            end
            default: action_nxt = ACT_IGNORED;
          endcase
        end
      end
      ST_SLIDE: begin
        if ((base_r != next_r) && marks_r[base_r]) begin
          marks_nxt[base_r] = 1'b0;
          base_nxt          = alu_y;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      base_r    <= '0;
      next_r    <= '0;
      marks_r   <= '0;
      retry_r   <= '0;
      aborted_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      base_r    <= base_nxt;
      next_r    <= next_nxt;
      marks_r   <= marks_nxt;
      retry_r   <= retry_nxt;
      aborted_r <= aborted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= func_t'(item_func);
      sn_r     <= item_seq_num;
      sn_idx_r <= SEQ_W'(item_seq_num);
      sn_in_r  <= (SNW'(item_seq_num) < SNW'(SEQ_SPACE));
      chk_r    <= item_check_ok;
    end
    if (state_r == ST_DNEXT) begin
      dnext_r <= alu_y;
    end
    if (state_r == ST_DSN) begin
      dsn_r <= alu_y;
    end
    thr_r    <= RETRY_W'(window_size) * RETRY_W'(retry_factor);
    action_r <= action_nxt;
    seqo_r   <= seqo_nxt;
    tstart_r <= tstart_nxt;
    tstop_r  <= tstop_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/core/srsw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsw_sva
// Port-level checks of the selective-repeat sender window unit.
// ----------------------------------------------------------------------------
module srsw_sva
  import srsw_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [ACTION_W-1:0] out_action,
  input wire logic [SEQ_FW-1:0]   out_seq_out,
  input wire logic                out_timer_start,
  input wire logic                out_timer_stop,
  input wire logic [SEQ_FW-1:0]   out_window_base,
  input wire logic                out_all_acked
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_seq_out) && $stable(out_window_base) && $stable(out_all_acked))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a transaction in back-to-back cycles");

  a_abort_no_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_ABORT) |-> !out_timer_start && !out_timer_stop)
    else $error("abort result drives a timer");

  a_sent_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_SENT) |-> out_timer_start && !out_timer_stop &&
      !out_all_acked)
    else $error("sent packet not outstanding");

endmodule

bind selective_repeat_sender_window_unit srsw_sva u_srsw_sva (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_action      (out_action),
  .out_seq_out     (out_seq_out),
  .out_timer_start (out_timer_start),
  .out_timer_stop  (out_timer_stop),
  .out_window_base (out_window_base),
  .out_all_acked   (out_all_acked)
);
`default_nettype wire
